// ===== hdl/rmpf_pkg.sv =====
// ============================================================================
// rmpf_pkg - shared types and constants of the mono page framebuffer
// Panel geometry, stream byte codes, colour widening tables and the Bayer
// ordered-dither matrix.
// ============================================================================
package rmpf_pkg;

    // Panel geometry
    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int PAGE_COUNT  = (ROWS + 7) / 8;
    localparam int PAGE_BYTES  = 7 + COLUMNS;
    localparam int STORE_DEPTH = PAGE_COUNT * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Operation codes of an input word
    typedef enum logic {
        OP_DRAW  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // Configuration register indexes
    localparam logic CFG_DITHER     = 1'b0;
    localparam logic CFG_COL_OFFSET = 1'b1;

    // Stream byte codes
    localparam logic [7:0] PFX_CMD      = 8'h00;
    localparam logic [7:0] PFX_DATA     = 8'h40;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;

    // Positions inside one page of the stream
    localparam logic [POS_W-1:0] POS_PFX0     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PAGE     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PFX1     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_COL_LOW  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PFX2     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_COL_HIGH = POS_W'(5);
    localparam logic [POS_W-1:0] POS_DATA_PFX = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DATA0    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PAGE_BYTES - 1);

    // Luminance weights and fixed threshold
    localparam logic [15:0] LUM_WR        = 16'd77;
    localparam logic [15:0] LUM_WG        = 16'd150;
    localparam logic [15:0] LUM_WB        = 16'd29;
    localparam logic [7:0]  LUM_FIXED_THR = 8'd128;

    typedef logic [31:0][7:0] t_lut5;
    typedef logic [63:0][7:0] t_lut6;

    function automatic t_lut5 build_widen5();
        t_lut5 lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = 8'((i * 255) / 31);
        end
        return lut;
    endfunction

    function automatic t_lut6 build_widen6();
        t_lut6 lut;
        for (int i = 0; i < 64; i++) begin
            lut[i] = 8'((i * 255) / 63);
        end
        return lut;
    endfunction

    // Widen 5 and 6 bit channels to 8 bits
    localparam t_lut5 WIDEN5 = build_widen5();
    localparam t_lut6 WIDEN6 = build_widen6();

    // 4x4 Bayer matrix, index is {y[1:0], x[1:0]}
    function automatic logic [3:0] bayer_value(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd8;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd10;
            4'd4:    v = 4'd12;
            4'd5:    v = 4'd4;
            4'd6:    v = 4'd14;
            4'd7:    v = 4'd6;
            4'd8:    v = 4'd3;
            4'd9:    v = 4'd11;
            4'd10:   v = 4'd1;
            4'd11:   v = 4'd9;
            4'd12:   v = 4'd15;
            4'd13:   v = 4'd7;
            4'd14:   v = 4'd13;
            4'd15:   v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/rmpf_if.sv =====
// ============================================================================
// rmpf_if - word channels of the mono page framebuffer
// Input channel carries draw/flush requests, output channel carries results.
// ============================================================================
interface rmpf_in_if import rmpf_pkg::*; ();
    logic        valid;
    logic        ready;
    t_op         operation;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;

    modport source (output valid, operation, pixel_x, pixel_y, pixel_color,
                    input ready);
    modport sink   (input valid, operation, pixel_x, pixel_y, pixel_color,
                    output ready);
endinterface

interface rmpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       transfer_start;
    logic       transfer_end;
    logic       flush_end;
    logic       pixel_lit;
    logic       range_error;

    modport source (output valid, out_byte, byte_valid, transfer_start,
                    transfer_end, flush_end, pixel_lit, range_error,
                    input ready);
    modport sink   (input valid, out_byte, byte_valid, transfer_start,
                    transfer_end, flush_end, pixel_lit, range_error,
                    output ready);
endinterface

// ===== hdl/rmpf_pixel_decide.sv =====
// ============================================================================
// rmpf_pixel_decide - RGB565 to on/off pixel decision
// Widens the channels, forms the weighted luminance and compares it with the
// fixed or the Bayer ordered-dither threshold.
// ============================================================================
module rmpf_pixel_decide import rmpf_pkg::*; (
    input  logic [15:0] i_color,
    input  logic [1:0]  i_x_lsb,
    input  logic [1:0]  i_y_lsb,
    input  logic        i_dither,
    output logic        o_lit
);

    logic [7:0]  red8;
    logic [7:0]  green8;
    logic [7:0]  blue8;
    logic [15:0] lum_sum;
    logic [7:0]  lum;
    logic [7:0]  bayer_thr;

    // Widen channels
    assign red8   = WIDEN5[i_color[15:11]];
    assign green8 = WIDEN6[i_color[10:5]];
    assign blue8  = WIDEN5[i_color[4:0]];

    // Weighted sum, top byte is the luminance
    assign lum_sum = 16'(16'(red8) * LUM_WR + 16'(green8) * LUM_WG
                         + 16'(blue8) * LUM_WB);
    assign lum     = lum_sum[15:8];

    // Threshold 16*B + 8
    assign bayer_thr = {bayer_value({i_y_lsb, i_x_lsb}), 4'h8};

    assign o_lit = i_dither ? (lum >= bayer_thr) : (lum >= LUM_FIXED_THR);

endmodule

// ===== hdl/rgb565_mono_page_framebuffer.sv =====
// ============================================================================
// rgb565_mono_page_framebuffer - RGB565 front end on a mono page framebuffer
// Draw words set or clear one bit of a page-organised byte store; flush
// words walk the bus refresh stream (command transfers, then page data).
//
//   channel  | dir | words
//   ---------+-----+-----------------------------------------------------
//   i_in     | in  | operation, pixel_x, pixel_y, pixel_color
//   o_out    | out | out_byte, byte_valid, transfer_start, transfer_end,
//            |     | flush_end, pixel_lit, range_error
//   i_cfg_*  | in  | write enable, register index, write data
//
// Each word has two steps: the accept edge reads the store (one port) into a
// register, then ST_CALC writes an in-range draw's modified byte back and
// loads the output register. One word is in the store loop at a time.
// After reset a clearing pass zeroes all STORE_DEPTH (1024) store bytes while
// i_in.ready is low; configuration writes are taken throughout.
// A full output register stalls the write-back until the word is taken.
// ============================================================================
module rgb565_mono_page_framebuffer import rmpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmpf_in_if.sink     i_in,
    rmpf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic       r_dither;
    logic [6:0] r_col_offset;

    // Clearing pass
    logic [ADDR_W-1:0] r_clr_addr;

    // Stream position
    logic [POS_W-1:0]  r_flush_pos;
    logic [PAGE_W-1:0] r_flush_page;

    // Word held across the store access
    t_op               r_op;
    logic [1:0]        r_x_lsb;
    logic [2:0]        r_y_lsb;
    logic [15:0]       r_color;
    logic              r_range_err;
    logic [ADDR_W-1:0] r_addr;
    logic [POS_W-1:0]  r_pos;
    logic [PAGE_W-1:0] r_page;

    // Store and its read data
    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_byte_valid;
    logic       r_out_start;
    logic       r_out_end;
    logic       r_out_fend;
    logic       r_out_lit;
    logic       r_out_range_err;

    logic              in_accept;
    logic              out_free;
    logic              finish;
    logic              in_range_err;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] flush_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              lit;
    logic [7:0]        bit_mask;
    logic [7:0]        draw_byte;
    logic [7:0]        flush_byte;
    logic              flush_start;
    logic              flush_last;
    logic              flush_fend;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;
    assign finish    = (r_state == ST_CALC) && out_free;

    // Address decode for both word kinds
    assign in_range_err = (9'(i_in.pixel_x) >= 9'(COLUMNS))
                       || (9'(i_in.pixel_y) >= 9'(ROWS));
    assign draw_addr  = ADDR_W'(ADDR_W'(i_in.pixel_y >> 3) * ADDR_W'(COLUMNS)
                                + ADDR_W'(i_in.pixel_x));
    assign flush_addr = ADDR_W'(ADDR_W'(r_flush_page) * ADDR_W'(COLUMNS)
                                + ADDR_W'(r_flush_pos - POS_DATA0));
    assign rd_addr    = (i_in.operation == OP_DRAW) ? draw_addr : flush_addr;

    // Pixel decision
    rmpf_pixel_decide u_decide (
        .i_color  (r_color),
        .i_x_lsb  (r_x_lsb),
        .i_y_lsb  (r_y_lsb[1:0]),
        .i_dither (r_dither),
        .o_lit    (lit)
    );

    // Read-modify of the addressed byte
    assign bit_mask  = 8'(1) << r_y_lsb;
    assign draw_byte = lit ? (r_rd_data | bit_mask) : (r_rd_data & ~bit_mask);

    // Stream byte for the held position
    always_comb begin
        flush_byte  = r_rd_data;
        flush_start = 1'b0;
        flush_last  = 1'b0;
        flush_fend  = 1'b0;
        case (r_pos)
            POS_PFX0, POS_PFX1, POS_PFX2: begin
                flush_byte  = PFX_CMD;
                flush_start = 1'b1;
            end
            POS_PAGE: begin
                flush_byte = 8'(CMD_PAGE + 8'(r_page));
                flush_last = 1'b1;
            end
            POS_COL_LOW: begin
                flush_byte = {4'h0, r_col_offset[3:0]};
                flush_last = 1'b1;
            end
            POS_COL_HIGH: begin
                flush_byte = 8'(CMD_COL_HIGH + {5'b0, r_col_offset[6:4]});
                flush_last = 1'b1;
            end
            POS_DATA_PFX: begin
                flush_byte  = PFX_DATA;
                flush_start = 1'b1;
            end
            default: begin
                flush_byte = r_rd_data;
                if (r_pos == POS_LAST) begin
                    flush_last = 1'b1;
                    flush_fend = (r_page == PAGE_W'(PAGE_COUNT - 1));
                end
            end
        endcase
    end

    // Store write port: clearing pass or draw write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = draw_byte;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else if (finish && (r_op == OP_DRAW) && !r_range_err) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_accept) n_state = ST_CALC;
            ST_CALC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dither     <= 1'b0;
            r_col_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DITHER:     r_dither     <= i_cfg_data[0];
                CFG_COL_OFFSET: r_col_offset <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Advance the stream position on each flush word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_pos  <= '0;
            r_flush_page <= '0;
        end else if (in_accept && (i_in.operation == OP_FLUSH)) begin
            if (r_flush_pos == POS_LAST) begin
                r_flush_pos <= '0;
                if (r_flush_page == PAGE_W'(PAGE_COUNT - 1)) begin
                    r_flush_page <= '0;
                end else begin
                    r_flush_page <= r_flush_page + 1'b1;
                end
            end else begin
                r_flush_pos <= r_flush_pos + 1'b1;
            end
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op        <= i_in.operation;
            r_x_lsb     <= i_in.pixel_x[1:0];
            r_y_lsb     <= i_in.pixel_y[2:0];
            r_color     <= i_in.pixel_color;
            r_range_err <= in_range_err;
            r_addr      <= draw_addr;
            r_pos       <= r_flush_pos;
            r_page      <= r_flush_page;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_op == OP_DRAW) begin
                r_out_byte       <= 8'h00;
                r_out_byte_valid <= 1'b0;
                r_out_start      <= 1'b0;
                r_out_end        <= 1'b0;
                r_out_fend       <= 1'b0;
                r_out_lit        <= lit && !r_range_err;
                r_out_range_err  <= r_range_err;
            end else begin
                r_out_byte       <= flush_byte;
                r_out_byte_valid <= 1'b1;
                r_out_start      <= flush_start;
                r_out_end        <= flush_last;
                r_out_fend       <= flush_fend;
                r_out_lit        <= 1'b0;
                r_out_range_err  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.byte_valid     = r_out_byte_valid;
    assign o_out.transfer_start = r_out_start;
    assign o_out.transfer_end   = r_out_end;
    assign o_out.flush_end      = r_out_fend;
    assign o_out.pixel_lit      = r_out_lit;
    assign o_out.range_error    = r_out_range_err;

endmodule
